FILE: src/tws_pkg.sv
`timescale 1ns / 1ps
package tws_pkg;

  localparam int CharW   = 8;
  localparam int DayW    = 3;
  localparam int MinuteW = 11;
  localparam int TimeW   = 13;
  localparam int CfgIdxW = 2;
  localparam int CfgDataW = 11;

  localparam logic [CfgIdxW-1:0] CFG_DAY     = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_MINUTE  = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_DEFAULT = 2'd2;

  localparam logic [CharW-1:0] CH_STAR  = 8'h2A;
  localparam logic [CharW-1:0] CH_COMMA = 8'h2C;
  localparam logic [CharW-1:0] CH_COLON = 8'h3A;
  localparam logic [CharW-1:0] CH_ZERO  = 8'h30;
  localparam logic [CharW-1:0] CH_SIX   = 8'h36;
  localparam logic [CharW-1:0] CH_NINE  = 8'h39;
  localparam logic [CharW-1:0] CH_UPPER_W = 8'h57;
  localparam logic [CharW-1:0] CH_LOWER_W = 8'h77;

  localparam logic [DayW-1:0] DAY_MON = 3'd1;
  localparam logic [DayW-1:0] DAY_FRI = 3'd5;

  localparam logic [2:0] FIELD_DIGITS = 3'd4;

  typedef struct packed {
    logic [2:0]       cnt;
    logic [TimeW-1:0] val;
    logic             ok;
  } field_t;

  typedef struct packed {
    logic       day_matched;
    logic       day_scan_done;
    logic [1:0] colon_count;
    field_t     start;
    field_t     stop;
  } seg_t;

  typedef struct packed {
    logic matched;
    logic any_found;
    logic bad_seen;
    seg_t seg;
  } parse_state_t;

  localparam field_t FIELD_CLEAR = '{cnt: 3'd0, val: 13'd0, ok: 1'b1};

  localparam seg_t SEG_CLEAR = '{
    day_matched: 1'b0,
    day_scan_done: 1'b0,
    colon_count: 2'd0,
    start: FIELD_CLEAR,
    stop: FIELD_CLEAR
  };

  localparam parse_state_t PARSE_CLEAR = '{
    matched: 1'b0,
    any_found: 1'b0,
    bad_seen: 1'b0,
    seg: SEG_CLEAR
  };

  typedef struct packed {
    logic [DayW-1:0]    day;
    logic [MinuteW-1:0] minute;
    logic               default_result;
  } cfg_t;

  typedef struct packed {
    logic produce;
    logic in_window;
    logic malformed;
  } verdict_t;

endpackage

FILE: src/tws_spec_if.sv
`timescale 1ns / 1ps
interface tws_spec_if;
  logic                       valid;
  logic                       ready;
  logic [tws_pkg::CharW-1:0]  spec_char;
  logic                       last;
  logic                       no_spec;

  modport source (output valid, output spec_char, output last, output no_spec, input ready);
  modport sink (input valid, input spec_char, input last, input no_spec, output ready);
endinterface

FILE: src/tws_result_if.sv
`timescale 1ns / 1ps
interface tws_result_if;
  logic valid;
  logic ready;
  logic in_window;
  logic malformed;

  modport source (output valid, output in_window, output malformed, input ready);
  modport sink (input valid, input in_window, input malformed, output ready);
endinterface

FILE: src/tws_cfg_if.sv
`timescale 1ns / 1ps
interface tws_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [tws_pkg::CfgIdxW-1:0]   index;
  logic [tws_pkg::CfgDataW-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

FILE: src/time_window_spec_matcher.sv
`timescale 1ns / 1ps
// channel   kind            word
// spec      sink            spec_char, last, no_spec
// result    source          in_window, malformed
// cfg       sink (write)    index, data (0 day, 1 minute, 2 default)
//
// one word accepted per cycle while no held result stalls the input; a word
// passes through the input register, then the result register
// rst clears parse state, configuration and both valid flags
// a held result stalls the input register, which then drops spec.ready
// cfg.ready is always high
module time_window_spec_matcher (
  input logic             clk,
  input logic             rst,
  tws_spec_if.sink        spec,
  tws_result_if.source    result,
  tws_cfg_if.sink         cfg
);

  tws_pkg::cfg_t             cfg_regs;
  tws_pkg::parse_state_t     state;
  tws_pkg::parse_state_t     state_next;
  tws_pkg::verdict_t         verdict;

  logic                      word_valid;
  logic [tws_pkg::CharW-1:0] word_char;
  logic                      word_last;
  logic                      word_no_spec;
  logic                      out_valid;
  logic                      out_in_window;
  logic                      out_malformed;
  logic                      advance;

  assign advance = word_valid && (!out_valid || result.ready);
  assign spec.ready = !word_valid || advance;
  assign cfg.ready = 1'b1;
  assign result.valid = out_valid;
  assign result.in_window = out_in_window;
  assign result.malformed = out_malformed;

  tws_parse u_parse (
    .cfg_regs   (cfg_regs),
    .state      (state),
    .spec_char  (word_char),
    .last       (word_last),
    .no_spec    (word_no_spec),
    .state_next (state_next),
    .verdict    (verdict)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs <= '0;
    end else if (cfg.valid) begin
      case (cfg.index)
        tws_pkg::CFG_DAY:     cfg_regs.day <= cfg.data[tws_pkg::DayW-1:0];
        tws_pkg::CFG_MINUTE:  cfg_regs.minute <= cfg.data[tws_pkg::MinuteW-1:0];
        tws_pkg::CFG_DEFAULT: cfg_regs.default_result <= cfg.data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word_valid <= 1'b0;
    end else if (spec.ready) begin
      word_valid <= spec.valid;
    end
    if (spec.ready && spec.valid) begin
      word_char <= spec.spec_char;
      word_last <= spec.last;
      word_no_spec <= spec.no_spec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tws_pkg::PARSE_CLEAR;
      out_valid <= 1'b0;
    end else begin
      if (advance) begin
        state <= state_next;
        out_valid <= verdict.produce;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
    if (advance && verdict.produce) begin
      out_in_window <= verdict.in_window;
      out_malformed <= verdict.malformed;
    end
  end

`ifndef SYNTHESIS
  a_hold_word: assert property (@(posedge clk) disable iff (rst)
    word_valid && !advance |=> word_valid)
    else $error("pending word lost");

  a_no_spec_clears: assert property (@(posedge clk) disable iff (rst)
    advance && word_no_spec |=> state == tws_pkg::PARSE_CLEAR)
    else $error("parse state not cleared after absent spec");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !spec.ready |-> word_valid && out_valid && !result.ready)
    else $error("input stalled without a held result");
`endif

endmodule

FILE: src/tws_parse.sv
`timescale 1ns / 1ps
module tws_parse (
  input  tws_pkg::cfg_t             cfg_regs,
  input  tws_pkg::parse_state_t     state,
  input  logic [tws_pkg::CharW-1:0] spec_char,
  input  logic                      last,
  input  logic                      no_spec,
  output tws_pkg::parse_state_t     state_next,
  output tws_pkg::verdict_t         verdict
);

  function automatic logic [tws_pkg::TimeW-1:0] digit_weight(input logic [1:0] pos);
    logic [tws_pkg::TimeW-1:0] w;
    case (pos)
      2'd0: w = 13'd600;
      2'd1: w = 13'd60;
      2'd2: w = 13'd10;
      default: w = 13'd1;
    endcase
    return w;
  endfunction

  function automatic tws_pkg::field_t feed_field(input tws_pkg::field_t f,
                                                 input logic [tws_pkg::CharW-1:0] c);
    tws_pkg::field_t r;
    r = f;
    if (f.cnt < tws_pkg::FIELD_DIGITS) begin
      if (c >= tws_pkg::CH_ZERO && c <= tws_pkg::CH_NINE) begin
        if (f.ok) begin
          r.val = f.val + {9'd0, c[3:0]} * digit_weight(f.cnt[1:0]);
        end
      end else begin
        r.ok = 1'b0;
      end
      r.cnt = f.cnt + 3'd1;
    end
    return r;
  endfunction

  // close a segment: flag bad forms, test the window
  function automatic tws_pkg::parse_state_t end_segment(input tws_pkg::parse_state_t p,
                                                        input tws_pkg::cfg_t cf);
    tws_pkg::parse_state_t r;
    logic sgood;
    logic egood;
    logic hit;
    logic [tws_pkg::TimeW-1:0] s;
    logic [tws_pkg::TimeW-1:0] e;
    logic [tws_pkg::TimeW-1:0] m;
    r = p;
    sgood = p.seg.start.ok && (p.seg.start.cnt == tws_pkg::FIELD_DIGITS);
    egood = p.seg.stop.ok && (p.seg.stop.cnt == tws_pkg::FIELD_DIGITS);
    s = sgood ? p.seg.start.val : '0;
    e = egood ? p.seg.stop.val : '0;
    m = {2'b00, cf.minute};
    if (e > s) begin
      hit = (m >= s) && (m <= e);
    end else begin
      hit = (m >= s) || (m <= e);
    end
    if (!p.seg.day_scan_done) begin
      r.bad_seen = 1'b1;
    end else if (p.seg.day_matched) begin
      if (p.seg.colon_count == 2'd0) begin
        r.bad_seen = 1'b1;
      end else begin
        if (!sgood) begin
          r.bad_seen = 1'b1;
        end
        if (p.seg.colon_count < 2'd2) begin
          r.bad_seen = 1'b1;
        end else begin
          if (!egood) begin
            r.bad_seen = 1'b1;
          end
          if (hit) begin
            r.any_found = 1'b1;
            r.matched = 1'b1;
          end
        end
      end
    end
    r.seg = tws_pkg::SEG_CLEAR;
    return r;
  endfunction

  function automatic tws_pkg::parse_state_t take_char(input tws_pkg::parse_state_t p,
                                                      input logic [tws_pkg::CharW-1:0] c,
                                                      input tws_pkg::cfg_t cf);
    tws_pkg::parse_state_t r;
    r = p;
    if (!p.seg.day_scan_done) begin
      if (c == tws_pkg::CH_STAR) begin
        r.seg.day_matched = 1'b1;
      end else if (c == tws_pkg::CH_UPPER_W || c == tws_pkg::CH_LOWER_W) begin
        if (cf.day >= tws_pkg::DAY_MON && cf.day <= tws_pkg::DAY_FRI) begin
          r.seg.day_matched = 1'b1;
        end
      end else if (c >= tws_pkg::CH_ZERO && c <= tws_pkg::CH_SIX) begin
        if (c[2:0] == cf.day) begin
          r.seg.day_matched = 1'b1;
        end
      end else if (c == tws_pkg::CH_COLON) begin
        r.seg.day_scan_done = 1'b1;
      end else begin
        r.bad_seen = 1'b1;
        r.seg.day_scan_done = 1'b1;
      end
      if (r.seg.day_matched) begin
        r.seg.day_scan_done = 1'b1;
      end
    end
    if (p.seg.colon_count >= 2'd1) begin
      r.seg.start = feed_field(p.seg.start, c);
    end
    if (p.seg.colon_count >= 2'd2) begin
      r.seg.stop = feed_field(p.seg.stop, c);
    end
    if (c == tws_pkg::CH_COLON && p.seg.colon_count < 2'd2) begin
      r.seg.colon_count = p.seg.colon_count + 2'd1;
    end
    return r;
  endfunction

  always_comb begin
    tws_pkg::parse_state_t p;
    p = state;
    verdict = '0;
    if (no_spec) begin
      p = tws_pkg::PARSE_CLEAR;
      verdict.produce = 1'b1;
      verdict.in_window = cfg_regs.default_result;
      verdict.malformed = 1'b0;
    end else begin
      if (!p.matched) begin
        if (spec_char == tws_pkg::CH_COMMA) begin
          p = end_segment(p, cfg_regs);
        end else begin
          p = take_char(p, spec_char, cfg_regs);
        end
      end
      if (last) begin
        if (!p.matched) begin
          p = end_segment(p, cfg_regs);
        end
        verdict.produce = 1'b1;
        verdict.in_window = p.any_found;
        verdict.malformed = p.bad_seen;
        p = tws_pkg::PARSE_CLEAR;
      end
    end
    state_next = p;
  end

endmodule

FILE: tb/time_window_spec_matcher_tb.sv
`timescale 1ns / 1ps
module time_window_spec_matcher_tb;
  import tws_pkg::*;

  localparam int HalfPeriod = 6;
  localparam int ItemTarget = 1750;
  localparam int PhaseCount = 9;
  localparam int LatencyPad = 4;
  localparam int HoldCycles = 400;
  localparam logic [7:0] NulMark = 8'h23;

  typedef struct packed {
    logic in_window;
    logic malformed;
  } verdict_word_t;

  typedef struct packed {
    logic absent;
    logic unfinished;
    logic typed;
    verdict_word_t known;
  } row_flags_t;

  logic clk = 1'b0;
  logic rst;

  always #(HalfPeriod) clk = ~clk;

  tws_spec_if spec_if ();
  tws_result_if result_if ();
  tws_cfg_if cfg_if ();

  time_window_spec_matcher u_dut (
    .clk    (clk),
    .rst    (rst),
    .spec   (spec_if),
    .result (result_if),
    .cfg    (cfg_if)
  );

  // expected verdicts, oldest first
  verdict_word_t window_q[$];
  int mismatches = 0;
  int items_sent = 0;
  bit spec_calm = 1'b0;
  bit result_calm = 1'b0;
  int hold_len = 0;

  string row_text[$];
  row_flags_t row_flags[$];
  logic [7:0] spec_buf[$];

  // predictor copy of configuration and parse state
  logic [DayW-1:0] day_reg;
  logic [MinuteW-1:0] minute_reg;
  logic default_reg;
  logic skip_rest, found_any, saw_bad, day_hit, day_done;
  logic [1:0] colons;
  logic [2:0] from_cnt, to_cnt;
  logic [TimeW-1:0] from_val, to_val;
  logic from_ok, to_ok;

  function automatic void reset_segment();
    day_hit = 1'b0;
    day_done = 1'b0;
    colons = 2'd0;
    from_cnt = 3'd0;
    from_val = '0;
    from_ok = 1'b1;
    to_cnt = 3'd0;
    to_val = '0;
    to_ok = 1'b1;
  endfunction

  function automatic void reset_parse();
    reset_segment();
    skip_rest = 1'b0;
    found_any = 1'b0;
    saw_bad = 1'b0;
  endfunction

  function automatic bit is_digit(input logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  function automatic void add_digit(input logic [7:0] c, inout logic [2:0] cnt,
                                    inout logic [TimeW-1:0] val, inout logic ok);
    logic [TimeW-1:0] weight;
    if (cnt >= FIELD_DIGITS) return;
    case (cnt)
      3'd0: weight = 13'd600;
      3'd1: weight = 13'd60;
      3'd2: weight = 13'd10;
      default: weight = 13'd1;
    endcase
    if (is_digit(c)) begin
      if (ok) val = val + TimeW'(c - CH_ZERO) * weight;
    end else begin
      ok = 1'b0;
    end
    cnt = cnt + 3'd1;
  endfunction

  function automatic void scan_weekday(input logic [7:0] c);
    if (c == CH_STAR) begin
      day_hit = 1'b1;
    end else if (c == CH_UPPER_W || c == CH_LOWER_W) begin
      if (day_reg >= DAY_MON && day_reg <= DAY_FRI) day_hit = 1'b1;
    end else if (c >= CH_ZERO && c <= CH_SIX) begin
      if (8'(c - CH_ZERO) == 8'(day_reg)) day_hit = 1'b1;
    end else if (c == CH_COLON) begin
      day_done = 1'b1;
    end else begin
      saw_bad = 1'b1;
      day_done = 1'b1;
    end
    if (day_hit) day_done = 1'b1;
  endfunction

  function automatic void close_segment();
    logic [TimeW-1:0] lo, hi;
    logic from_good, to_good, covered;
    from_good = from_ok && from_cnt == FIELD_DIGITS;
    to_good = to_ok && to_cnt == FIELD_DIGITS;
    if (!day_done) begin
      saw_bad = 1'b1;
    end else if (day_hit) begin
      if (colons == 2'd0) begin
        saw_bad = 1'b1;
      end else begin
        lo = from_good ? from_val : '0;
        if (!from_good) saw_bad = 1'b1;
        if (colons < 2'd2) begin
          saw_bad = 1'b1;
        end else begin
          hi = to_good ? to_val : '0;
          if (!to_good) saw_bad = 1'b1;
          // window wraps past midnight unless end is above start
          if (hi > lo) covered = TimeW'(minute_reg) >= lo && TimeW'(minute_reg) <= hi;
          else covered = TimeW'(minute_reg) >= lo || TimeW'(minute_reg) <= hi;
          if (covered) begin
            found_any = 1'b1;
            skip_rest = 1'b1;
          end
        end
      end
    end
    reset_segment();
  endfunction

  function automatic bit predict_window(input logic [7:0] c, input logic last,
                                        input logic absent, output verdict_word_t v);
    v = '0;
    if (absent) begin
      reset_parse();
      v.in_window = default_reg;
      return 1'b1;
    end
    if (!skip_rest) begin
      if (c == CH_COMMA) begin
        close_segment();
      end else begin
        if (!day_done) scan_weekday(c);
        if (colons >= 2'd1) add_digit(c, from_cnt, from_val, from_ok);
        if (colons >= 2'd2) add_digit(c, to_cnt, to_val, to_ok);
        if (c == CH_COLON && colons < 2'd2) colons = colons + 2'd1;
      end
    end
    if (!last) return 1'b0;
    if (!skip_rest) close_segment();
    v.in_window = found_any;
    v.malformed = saw_bad;
    reset_parse();
    return 1'b1;
  endfunction

  task automatic flag_error(input string msg);
    if (mismatches < 10) $display("%0t: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic offer_word(input logic [7:0] c, input logic last, input logic absent,
                            input bit typed = 1'b0, input verdict_word_t known = '0);
    int gap;
    bit has;
    verdict_word_t v;
    gap = spec_calm ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      spec_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    spec_if.valid <= 1'b1;
    spec_if.spec_char <= c;
    spec_if.last <= last;
    spec_if.no_spec <= absent;
    do @(posedge clk); while (spec_if.ready !== 1'b1);
    has = predict_window(c, last, absent, v);
    if (has) window_q.push_back(typed ? known : v);
    items_sent++;
  endtask

  task automatic drain();
    spec_if.valid <= 1'b0;
    while (window_q.size() != 0) @(posedge clk);
    repeat (LatencyPad) @(posedge clk);
  endtask

  task automatic program_regs(input logic [DayW-1:0] d, input logic [MinuteW-1:0] m,
                              input logic dr);
    logic [CfgIdxW-1:0] regs [3];
    logic [CfgDataW-1:0] vals [3];
    regs[0] = CFG_DAY;
    regs[1] = CFG_MINUTE;
    regs[2] = CFG_DEFAULT;
    vals[0] = CfgDataW'(d);
    vals[1] = CfgDataW'(m);
    vals[2] = CfgDataW'(dr);
    for (int i = 0; i < 3; i++) begin
      cfg_if.valid <= 1'b1;
      cfg_if.index <= regs[i];
      cfg_if.data <= vals[i];
      do @(posedge clk); while (cfg_if.ready !== 1'b1);
    end
    cfg_if.valid <= 1'b0;
    day_reg = d;
    minute_reg = m;
    default_reg = dr;
  endtask

  function automatic void add_row(input string text, input bit absent, input bit unfinished,
                                  input bit typed, input bit win, input bit bad);
    row_flags_t f;
    f.absent = absent;
    f.unfinished = unfinished;
    f.typed = typed;
    f.known = {win, bad};
    row_text.push_back(text);
    row_flags.push_back(f);
  endfunction

  task automatic walk_rows(input int first, input int stop);
    string text;
    row_flags_t f;
    logic [7:0] c;
    logic last;
    for (int r = first; r < stop; r++) begin
      text = row_text[r];
      f = row_flags[r];
      if (f.absent) begin
        offer_word(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1, f.typed, f.known);
      end else begin
        for (int i = 0; i < text.len(); i++) begin
          c = text[i];
          if (c == NulMark) c = 8'h00;
          last = !f.unfinished && i == text.len() - 1;
          offer_word(c, last, 1'b0, f.typed && last, f.known);
        end
      end
    end
  endtask

  function automatic void push_hhmm();
    int t;
    if ($urandom_range(0, 4) == 0) begin
      repeat (4) spec_buf.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
    end else begin
      if ($urandom_range(0, 1) == 1) t = (int'(minute_reg) + 1438 + $urandom_range(0, 4)) % 1440;
      else t = $urandom_range(0, 1439);
      spec_buf.push_back(8'(CH_ZERO + (t / 60) / 10));
      spec_buf.push_back(8'(CH_ZERO + (t / 60) % 10));
      spec_buf.push_back(8'(CH_ZERO + (t % 60) / 10));
      spec_buf.push_back(8'(CH_ZERO + (t % 60) % 10));
    end
  endfunction

  function automatic void build_random_spec(input bit noise);
    int pos;
    spec_buf.delete();
    if (noise) begin
      repeat ($urandom_range(1, 12)) begin
        case ($urandom_range(0, 5))
          0: spec_buf.push_back(CH_COLON);
          1: spec_buf.push_back(CH_COMMA);
          2: spec_buf.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
          default: spec_buf.push_back(8'($urandom_range(0, 255)));
        endcase
      end
      return;
    end
    for (int s = 0; s < $urandom_range(1, 3); s++) begin
      if (s > 0) spec_buf.push_back(CH_COMMA);
      repeat ($urandom_range(1, 3)) begin
        case ($urandom_range(0, 9))
          0: spec_buf.push_back(CH_STAR);
          1: spec_buf.push_back(CH_UPPER_W);
          2: spec_buf.push_back(CH_LOWER_W);
          default: spec_buf.push_back(8'(CH_ZERO + $urandom_range(0, 6)));
        endcase
      end
      spec_buf.push_back(CH_COLON);
      push_hhmm();
      spec_buf.push_back(CH_COLON);
      push_hhmm();
    end
    // damaged schedules
    if ($urandom_range(0, 3) == 0) begin
      pos = $urandom_range(0, spec_buf.size() - 1);
      case ($urandom_range(0, 3))
        0: spec_buf[pos] = 8'($urandom_range(0, 255));
        1: spec_buf.delete(pos);
        2: while (spec_buf.size() > pos + 1) spec_buf.pop_back();
        default: begin
          spec_buf.push_back($urandom_range(0, 1) == 1 ? CH_COMMA : CH_COLON);
          if ($urandom_range(0, 1) == 1) spec_buf.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
        end
      endcase
      if (spec_buf.size() == 0) spec_buf.push_back(CH_STAR);
    end
  endfunction

  task automatic send_random_spec();
    int kind;
    int cut;
    kind = $urandom_range(0, 19);
    if (kind == 0) begin
      offer_word(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
    end else begin
      build_random_spec(kind <= 2);
      if (kind == 3 && spec_buf.size() > 1) begin
        // spec abandoned midway by an absent-spec word
        cut = $urandom_range(1, spec_buf.size() - 1);
        for (int i = 0; i < cut; i++) offer_word(spec_buf[i], 1'b0, 1'b0);
        offer_word(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
      end else begin
        for (int i = 0; i < spec_buf.size(); i++)
          offer_word(spec_buf[i], i == spec_buf.size() - 1, 1'b0);
      end
    end
  endtask

  initial begin : result_sink
    int stall;
    verdict_word_t got, want;
    result_if.ready <= 1'b0;
    wait (rst === 1'b0);
    forever begin
      if (hold_len > 0) begin
        stall = hold_len;
        hold_len = 0;
      end else begin
        stall = result_calm ? 0 : $urandom_range(0, 19);
      end
      if (stall > 0) begin
        result_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      result_if.ready <= 1'b1;
      do @(posedge clk); while (result_if.valid !== 1'b1);
      got = {result_if.in_window, result_if.malformed};
      if (window_q.size() == 0) begin
        flag_error($sformatf("result word with none expected: in_window %0b malformed %0b",
                             got.in_window, got.malformed));
      end else begin
        want = window_q.pop_front();
        if (got.in_window !== want.in_window || got.malformed !== want.malformed)
          flag_error($sformatf("in_window exp %0b got %0b, malformed exp %0b got %0b",
                               want.in_window, got.in_window, want.malformed, got.malformed));
      end
    end
  end

  initial begin
    #(10_000_000);
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    int goal;
    rst <= 1'b1;
    spec_if.valid <= 1'b0;
    spec_if.spec_char <= '0;
    spec_if.last <= 1'b0;
    spec_if.no_spec <= 1'b0;
    cfg_if.valid <= 1'b0;
    cfg_if.index <= CFG_DAY;
    cfg_if.data <= '0;
    day_reg = '0;
    minute_reg = '0;
    default_reg = 1'b0;
    reset_parse();

    // registers at reset: sunday, midnight, default 0
    add_row("", 1, 0, 1, 0, 0);
    add_row("0:0000:0000", 0, 0, 1, 1, 0);
    // wednesday 10:00, default 1
    add_row("", 1, 0, 1, 1, 0);
    add_row("*:0000:2359", 0, 0, 1, 1, 0);
    add_row("3:0900:1100", 0, 0, 1, 1, 0);
    add_row("W:1000:1000", 0, 0, 0, 0, 0);
    add_row("w:1001:0959", 0, 0, 0, 0, 0);
    add_row("0:0000:2359", 0, 0, 1, 0, 0);
    add_row("X:0000:2359", 0, 0, 1, 0, 1);
    add_row("*", 0, 0, 1, 0, 1);
    add_row("*:1000", 0, 0, 1, 0, 1);
    add_row("*:10a0:2359", 0, 0, 1, 1, 1);
    add_row("*:0000:99", 0, 0, 0, 0, 0);
    add_row("5,3:0000:2359", 0, 0, 0, 0, 0);
    add_row("*:0000:2359,X", 0, 0, 0, 0, 0);
    add_row("3:0000:0100,", 0, 0, 0, 0, 0);
    // # stands for a nul byte
    add_row("#", 0, 0, 1, 0, 1);
    add_row("\377", 0, 0, 1, 0, 1);
    add_row("6W*:2300:0100", 0, 0, 0, 0, 0);
    add_row("**:2359:2359", 0, 0, 0, 0, 0);
    add_row("3::0000", 0, 0, 0, 0, 0);
    add_row("*:1959:2359:1", 0, 0, 0, 0, 0);
    add_row(",*:0000:2359", 0, 0, 0, 0, 0);
    add_row("*:00", 0, 1, 0, 0, 0);
    add_row("", 1, 0, 1, 1, 0);

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    walk_rows(0, 2);
    drain();
    program_regs(3'd3, 11'd600, 1'b1);
    walk_rows(2, row_text.size());
    drain();

    for (int p = 0; p < PhaseCount; p++) begin
      case (p)
        0: program_regs(3'd0, 11'd0, 1'b0);
        1: program_regs(3'd6, 11'd1439, 1'b1);
        2: program_regs(3'd7, 11'd2047, 1'b0);
        default: program_regs(3'($urandom_range(0, 6)), 11'($urandom_range(0, 1439)),
                              1'($urandom_range(0, 1)));
      endcase
      spec_calm = $urandom_range(0, 2) == 0;
      result_calm = $urandom_range(0, 2) == 0;
      if (p == 3) begin
        // long receiver hold while words keep coming
        spec_calm = 1'b1;
        hold_len = HoldCycles;
      end
      goal = items_sent + (ItemTarget - items_sent) / (PhaseCount - p);
      while (items_sent < goal) send_random_spec();
      drain();
    end

    if (mismatches == 0 && window_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
